// ----- rtl/core/spcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcd_pkg
// Shared types and constants for the sphere pair collision detector.
// ----------------------------------------------------------------------------
package spcd_pkg;

    localparam int MAX_BALLS_DEF = 64;
    localparam logic [1:0] DIMS_RESET = 2'd3;

    // One ball as it enters the block.
    typedef struct packed {
        logic               start_new_set;
        logic signed [15:0] coord_0;
        logic signed [15:0] coord_1;
        logic signed [15:0] coord_2;
        logic        [15:0] radius;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic       pair_found;
        logic [5:0] first_index;
        logic [5:0] second_index;
        logic       set_full;
        logic       last;
    } t_out_word;

    // Stored ball.
    typedef struct packed {
        logic signed [15:0] c0;
        logic signed [15:0] c1;
        logic signed [15:0] c2;
        logic        [15:0] r;
    } t_ball;

    // Broadcast from the controller into the cell row.
    typedef struct packed {
        logic       clear;
        logic [1:0] dims;
    } t_cell_ctl;

endpackage

// ----- rtl/core/spcd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcd_cell
// One stored ball slot; compares its ball with the probe passing through.
// ----------------------------------------------------------------------------
module spcd_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spcd_pkg::t_cell_ctl i_ctl,
    input  logic               i_wr,
    input  spcd_pkg::t_ball    i_wball,
    input  spcd_pkg::t_ball    i_probe,
    input  logic               i_pvalid,
    output spcd_pkg::t_ball    o_probe,
    output logic               o_pvalid,
    output logic               o_hit
);
    spcd_pkg::t_ball r_ball;
    logic            r_full;
    spcd_pkg::t_ball r_probe;
    logic            r_pvalid;
    logic [33:0]     r_sq0, r_sq1, r_sq2;
    logic [33:0]     r_r2;
    logic            r_s1v;
    logic            r_hit;

    logic signed [16:0] d0, d1, d2;
    logic        [16:0] a0, a1, a2, rs;
    logic        [35:0] dist_sq;

    // Stored ball and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_ctl.clear) begin
            r_full <= 1'b0;
        end else if (i_wr) begin
            r_full <= 1'b1;
        end
        if (i_wr) begin
            r_ball <= i_wball;
        end
    end

    // Stage one: squared differences and squared radius sum.
    always_comb begin
        d0 = 17'(i_probe.c0) - 17'(r_ball.c0);
        d1 = 17'(i_probe.c1) - 17'(r_ball.c1);
        d2 = 17'(i_probe.c2) - 17'(r_ball.c2);
        a0 = d0[16] ? 17'(-d0) : 17'(d0);
        a1 = d1[16] ? 17'(-d1) : 17'(d1);
        a2 = d2[16] ? 17'(-d2) : 17'(d2);
        rs = {1'b0, i_probe.r} + {1'b0, r_ball.r};
        dist_sq = {2'b0, r_sq0} + ((i_ctl.dims >= 2'd2) ? {2'b0, r_sq1} : 36'd0)
                + ((i_ctl.dims == 2'd3) ? {2'b0, r_sq2} : 36'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_s1v    <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_pvalid <= i_pvalid;
            r_s1v    <= i_pvalid & r_full;
            r_hit    <= r_s1v && (dist_sq <= {2'b0, r_r2});
        end
        r_probe <= i_probe;
        r_sq0   <= a0 * a0;
        r_sq1   <= a1 * a1;
        r_sq2   <= a2 * a2;
        r_r2    <= rs * rs;
    end

    assign o_probe  = r_probe;
    assign o_pvalid = r_pvalid;
    assign o_hit    = r_hit;
endmodule

// ----- rtl/core/sphere_pair_collision_detect.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_pair_collision_detect
// All-pairs sphere overlap test over a row of ball cells.
// ----------------------------------------------------------------------------
// The probe walks one cell per cycle down the row; each cell registers its
// squares, then its hit flag, after the probe reaches it, and pairs leave one
// per cycle in ascending index followed by the closing word. A dropped ball
// skips the row and yields only its closing word. The receiver cannot stall.
// Reset empties the set and sets the dimension register to three.
module sphere_pair_collision_detect #(
    parameter int MAX_BALLS = spcd_pkg::MAX_BALLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  spcd_pkg::t_in_word  i_word,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_data,
    output logic                o_strobe,
    output spcd_pkg::t_out_word o_word
);
    localparam int IW = $clog2(MAX_BALLS);
    localparam int CW = $clog2(MAX_BALLS + 1);
    localparam int TW = $clog2(MAX_BALLS + 8);
    localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_DONE = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          r_dims;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic [TW-1:0]       r_tick;
    logic                r_full_drop;
    spcd_pkg::t_ball     r_ball;
    spcd_pkg::t_cell_ctl ctl;
    logic                accept;

    spcd_pkg::t_ball     probe [MAX_BALLS+1];
    logic                pv    [MAX_BALLS+1];
    logic [MAX_BALLS-1:0] hit;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        ctl.clear = accept && i_word.start_new_set;
        ctl.dims  = (r_dims == 2'd0) ? 2'd1 : r_dims;
    end

    assign probe[0] = r_ball;
    assign pv[0]    = (r_state == S_RUN) && (r_tick == '0);

    // Cell row; each cell sees the probe in the cycle after its left neighbor.
    for (genvar g = 0; g < MAX_BALLS; g++) begin : g_cell
        spcd_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_wr     ((r_state == S_DONE) && !r_full_drop && (r_idx == CW'(g))),
            .i_wball  (r_ball),
            .i_probe  (probe[g]),
            .i_pvalid (pv[g]),
            .o_probe  (probe[g+1]),
            .o_pvalid (pv[g+1]),
            .o_hit    (hit[g])
        );
    end

    // Cell g reports at tick g + 2; tick MAX_BALLS + 1 closes the run.
    logic [TW-1:0] cell_sel;
    logic          emit_hit;
    always_comb begin
        cell_sel = r_tick - TW'(2);
        emit_hit = (r_state == S_RUN) && (r_tick >= TW'(2))
                && (cell_sel < TW'(MAX_BALLS)) && hit[cell_sel[IW-1:0]]
                && (cell_sel < TW'(r_idx));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dims   <= spcd_pkg::DIMS_RESET;
            r_count  <= '0;
            o_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dims <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    o_strobe <= 1'b0;
                    if (accept) begin
                        r_idx       <= i_word.start_new_set ? '0 : r_count;
                        r_full_drop <= !i_word.start_new_set
                                    && (r_count >= CW'(MAX_BALLS));
                        r_tick      <= '0;
                        r_ball      <= '{i_word.coord_0, i_word.coord_1,
                                         i_word.coord_2, i_word.radius};
                        if (i_word.start_new_set) r_count <= '0;
                        r_state     <= (!i_word.start_new_set
                                     && (r_count >= CW'(MAX_BALLS))) ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    r_tick   <= r_tick + TW'(1);
                    o_strobe <= emit_hit;
                    if (emit_hit) begin
                        o_word <= '{1'b1, 6'(cell_sel), 6'(r_idx), 1'b0, 1'b0};
                    end
                    if (r_tick == TW'(MAX_BALLS + 1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    o_strobe <= 1'b1;
                    if (r_full_drop) begin
                        o_word <= '{1'b0, 6'd0, 6'd0, 1'b1, 1'b1};
                    end else begin
                        o_word  <= '{1'b0, 6'd0, 6'(r_idx), 1'b0, 1'b1};
                        r_count <= r_idx + CW'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    o_strobe <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    // A closing word always ends a run before a new ball is taken.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (o_strobe && o_word.last && !busy))
        else $error("closing word missing");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BALLS)) else $error("ball count overflow");
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.pair_found) |-> (o_word.first_index < o_word.second_index))
        else $error("pair order wrong");
endmodule

// ----- verif/sphere_pair_collision_detect_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_pair_collision_detect_chk
// Watches the ball, result and register channels of the collision detector.
// It keeps its own copy of the stored balls and of the dimension register.
// For every accepted ball it predicts the colliding pairs and the closing
// word. It then compares each strobed result word with the oldest prediction.
// ----------------------------------------------------------------------------
module sphere_pair_collision_detect_chk #(
    parameter int MAX_BALLS = spcd_pkg::MAX_BALLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  spcd_pkg::t_in_word  i_word,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_data,
    input  logic                o_strobe,
    input  spcd_pkg::t_out_word o_word,
    output int                  o_fail_count,
    output int                  o_pending
);

    spcd_pkg::t_ball     stored_balls [MAX_BALLS];
    int                  held_balls;
    logic [1:0]          dim_reg;
    spcd_pkg::t_out_word expected_words [$];

    assign o_pending = expected_words.size();

    // Squared sum of the radii against the squared centre distance.
    function automatic logic balls_touch(spcd_pkg::t_ball a, spcd_pkg::t_ball b, int dims);
        longint d0, d1, d2;
        longint unsigned dist2, rsum;
        d0 = longint'(a.c0) - longint'(b.c0);
        d1 = longint'(a.c1) - longint'(b.c1);
        d2 = longint'(a.c2) - longint'(b.c2);
        dist2 = d0 * d0;
        if (dims >= 2) dist2 += d1 * d1;
        if (dims >= 3) dist2 += d2 * d2;
        rsum = longint'(a.r) + longint'(b.r);
        return dist2 <= rsum * rsum;
    endfunction

    // Queue the pair words and the closing word for one accepted ball.
    task automatic predict_contacts(spcd_pkg::t_in_word w);
        spcd_pkg::t_out_word o;
        spcd_pkg::t_ball     nb;
        int                  dims;
        dims = (dim_reg == 2'd0) ? 1 : int'(dim_reg);
        if (w.start_new_set) held_balls = 0;
        o = '0;
        o.last = 1'b1;
        if (held_balls >= MAX_BALLS) begin
            o.set_full = 1'b1;
            expected_words = {expected_words, o};
            return;
        end
        nb = '{c0: w.coord_0, c1: w.coord_1, c2: w.coord_2, r: w.radius};
        for (int j = 0; j < held_balls; j++) begin
            if (balls_touch(stored_balls[j], nb, dims)) begin
                spcd_pkg::t_out_word p;
                p = '0;
                p.pair_found = 1'b1;
                p.first_index = j[5:0];
                p.second_index = held_balls[5:0];
                expected_words = {expected_words, p};
            end
        end
        o.second_index = held_balls[5:0];
        expected_words = {expected_words, o};
        stored_balls[held_balls] = nb;
        held_balls++;
    endtask

    // Model update and comparison at each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_balls = 0;
            dim_reg = spcd_pkg::DIMS_RESET;
            expected_words.delete();
            o_fail_count <= 0;
        end else begin
            if (start && !busy) predict_contacts(i_word);
            if (i_cfg_we) dim_reg = i_cfg_data;
            if (o_strobe) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word %p", o_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    spcd_pkg::t_out_word e;
                    int errs;
                    e = expected_words.pop_front();
                    errs = 0;
                    if (o_word.pair_found !== e.pair_found) begin
                        $error("pair_found exp %0d got %0d", e.pair_found, o_word.pair_found);
                        errs++;
                    end
                    if (o_word.first_index !== e.first_index) begin
                        $error("first_index exp %0d got %0d", e.first_index,
                               o_word.first_index);
                        errs++;
                    end
                    if (o_word.second_index !== e.second_index) begin
                        $error("second_index exp %0d got %0d", e.second_index,
                               o_word.second_index);
                        errs++;
                    end
                    if (o_word.set_full !== e.set_full) begin
                        $error("set_full exp %0d got %0d", e.set_full, o_word.set_full);
                        errs++;
                    end
                    if (o_word.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, o_word.last);
                        errs++;
                    end
                    o_fail_count <= o_fail_count + errs;
                end
            end
        end
    end

endmodule

// ----- verif/sphere_pair_collision_detect_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_pair_collision_detect_tb
// Stimulus and verdict for the sphere pair collision detector.
// Directed balls cover coordinate and radius extremes, exact touching and
// identical centres. Random sets of clustered or spread balls follow, under
// every dimension setting, with one set driven past capacity.
// ----------------------------------------------------------------------------
module sphere_pair_collision_detect_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = spcd_pkg::MAX_BALLS_DEF + 16;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    spcd_pkg::t_in_word  i_word = '0;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_data = '0;
    logic                o_strobe;
    spcd_pkg::t_out_word o_word;
    int                  fail_count;
    int                  pending;
    int                  quiet_cycles = 0;
    logic                no_idle = 1'b0;

    always #5 i_clk = ~i_clk;

    sphere_pair_collision_detect uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_word(i_word), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_word(o_word)
    );

    sphere_pair_collision_detect_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_word(i_word), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_word(o_word),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog on cycles without an accepted ball, a result word or a register write.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL sphere_pair_collision_detect");
                $finish;
            end
        end
    end

    // Present one ball after a random gap, none when no_idle is set, and hold it until taken.
    task automatic send_ball(spcd_pkg::t_in_word w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_word <= w;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Let all results drain, then write the dimension register.
    task automatic write_dims(logic [1:0] v);
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic spcd_pkg::t_in_word make_ball(logic sns, int c0, int c1,
                                                     int c2, int r);
        spcd_pkg::t_in_word w;
        w.start_new_set = sns;
        w.coord_0 = c0[15:0];
        w.coord_1 = c1[15:0];
        w.coord_2 = c2[15:0];
        w.radius = r[15:0];
        return w;
    endfunction

    // Clustered balls collide often; spread balls exercise every bit.
    function automatic spcd_pkg::t_in_word random_ball(logic sns, logic clustered);
        spcd_pkg::t_in_word w;
        if (clustered) begin
            w = make_ball(sns, $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                          $urandom_range(0, 400) - 200, $urandom_range(0, 120));
        end else begin
            w = spcd_pkg::t_in_word'({$urandom, $urandom});
            w.start_new_set = sns;
        end
        return w;
    endfunction

    initial begin
        logic [1:0] dim_seq [5];
        int set_len;
        logic clustered;
        dim_seq = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed balls under the reset setting of three dimensions.
        send_ball(make_ball(1'b1, 0, 0, 0, 0));
        send_ball(make_ball(1'b0, 0, 0, 0, 0));
        send_ball(make_ball(1'b0, 3, 4, 0, 5));
        send_ball(make_ball(1'b0, 3, 4, 1, 0));
        send_ball(make_ball(1'b0, -32768, -32768, -32768, 0));
        send_ball(make_ball(1'b0, 32767, 32767, 32767, 0));
        send_ball(make_ball(1'b0, 32767, 32767, 32767, 65535));
        send_ball(make_ball(1'b0, -32768, -32768, -32768, 65535));
        send_ball(make_ball(1'b1, -32768, 32767, -32768, 32768));
        send_ball(make_ball(1'b0, 32767, -32768, 32767, 32767));
        send_ball(make_ball(1'b0, 100, 0, 0, 50));
        send_ball(make_ball(1'b0, 200, 0, 0, 49));
        send_ball(make_ball(1'b0, -1, -1, -1, 1));

        // Random sets under each dimension setting.
        for (int p = 0; p < 5; p++) begin
            int sent;
            if (p > 0) write_dims(dim_seq[p]);
            sent = 0;
            while (sent < 55) begin
                set_len = (p == 2 && sent == 0) ? spcd_pkg::MAX_BALLS_DEF + 3
                                                : $urandom_range(1, 14);
                clustered = ($urandom_range(0, 3) != 0);
                no_idle = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < set_len; k++) begin
                    logic sns;
                    sns = (k == 0) ? ($urandom_range(0, 5) != 0) : 1'b0;
                    send_ball(random_ball(sns, clustered));
                end
                sent += set_len;
            end
        end

        // Drain the last results and give the verdict.
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS sphere_pair_collision_detect");
        end else begin
            $display("FAIL sphere_pair_collision_detect");
        end
        $finish;
    end

endmodule
